// ----- rtl/hbb_pkg.sv -----
// package: shared constants, types and register indexes of the heater controller
`timescale 1ns / 1ps
`default_nettype none
package hbb_pkg;

	localparam int TEMP_W          = 13;
	localparam int DWELL_W         = 8;
	localparam int GOOD_W          = 12;
	localparam int MAX_FIELDS      = 4;
	localparam int NUM_SENSORS_DEF = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 13;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [DWELL_W-1:0]       dwell_t;

	localparam temp_t  GOOD_HIGH        = 13'sd3200;
	localparam temp_t  SETPOINT_RST     = 13'sd0;
	localparam temp_t  MIN_LEGAL_RST    = -13'sd880;
	localparam temp_t  MAX_LEGAL_RST    = 13'sd2000;
	localparam dwell_t DWELL_LIMIT_RST  = 8'd10;
	localparam temp_t  DISCONNECT_RST   = -13'sd2032;
	localparam dwell_t DWELL_COUNT_RST  = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT    = 3'd0,
		REG_MIN_LEGAL   = 3'd1,
		REG_MAX_LEGAL   = 3'd2,
		REG_DWELL_LIMIT = 3'd3,
		REG_DISCONNECT  = 3'd4
	} cfg_idx_e;

	typedef struct packed {
		logic              bad;
		logic              good;
		logic [GOOD_W-1:0] val;
	} hbb_lane_t;

	typedef struct packed {
		logic heater_on;
		logic safety_latched;
	} hbb_res_t;

endpackage
`default_nettype wire

// ----- rtl/hbb_sensor_if.sv -----
// interface: sensor item channel, four readings per item
`timescale 1ns / 1ps
`default_nettype none
interface hbb_sensor_if;
	logic           valid;
	logic           ready;
	hbb_pkg::temp_t temp_a;
	hbb_pkg::temp_t temp_b;
	hbb_pkg::temp_t temp_c;
	hbb_pkg::temp_t temp_d;

	modport source (output valid, output temp_a, output temp_b, output temp_c,
		output temp_d, input ready);
	modport sink (input valid, input temp_a, input temp_b, input temp_c,
		input temp_d, output ready);
endinterface
`default_nettype wire

// ----- rtl/hbb_result_if.sv -----
// interface: result item channel, heater drive and latch status
`timescale 1ns / 1ps
`default_nettype none
interface hbb_result_if;
	logic valid;
	logic ready;
	logic heater_on;
	logic safety_latched;

	modport source (output valid, output heater_on, output safety_latched, input ready);
	modport sink (input valid, input heater_on, input safety_latched, output ready);
endinterface
`default_nettype wire

// ----- rtl/hbb_lane.sv -----
// lane: legality and good-range check of one reading
`timescale 1ns / 1ps
`default_nettype none
module hbb_lane (
	input  hbb_pkg::temp_t    temp,
	input  hbb_pkg::temp_t    min_legal,
	input  hbb_pkg::temp_t    max_legal,
	input  hbb_pkg::temp_t    disconnect,
	output hbb_pkg::hbb_lane_t lane
);
	import hbb_pkg::*;

	always_comb begin
		lane.bad  = (temp == disconnect) || (temp < min_legal) || (temp > max_legal);
		lane.good = (temp > 13'sd0) && (temp < GOOD_HIGH);
		lane.val  = lane.good ? temp[GOOD_W-1:0] : '0;
	end
endmodule
`default_nettype wire

// ----- rtl/hbb_merge.sv -----
// merge: sums lane results, decides heater state, holds dwell and latch state
`timescale 1ns / 1ps
`default_nettype none
module hbb_merge #(
	parameter int LANES = hbb_pkg::NUM_SENSORS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  hbb_pkg::hbb_lane_t lanes [LANES],
	input  hbb_pkg::temp_t     setpoint,
	input  hbb_pkg::dwell_t    dwell_limit,
	output hbb_pkg::hbb_res_t  res
);
	import hbb_pkg::*;

	localparam int CNT_W  = $clog2(LANES + 1);
	localparam int SUM_W  = GOOD_W + CNT_W;
	localparam int PROD_W = TEMP_W + CNT_W + 1;

	logic                     heater_q;
	dwell_t                   dwell_q;
	logic                     unsafe_q;

	logic                     illegal;
	logic [CNT_W-1:0]         cnt;
	logic [SUM_W-1:0]         sum;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] sum_ext;
	logic                     want;
	logic [DWELL_W:0]         inc;
	dwell_t                   dwell_sat;
	logic                     do_switch;
	logic                     heater_next;
	dwell_t                   dwell_next;

	always_comb begin
		illegal = 1'b0;
		cnt     = '0;
		sum     = '0;
		for (int i = 0; i < LANES; i++) begin
			illegal = illegal | lanes[i].bad;
			cnt     = cnt + CNT_W'(lanes[i].good);
			sum     = sum + SUM_W'(lanes[i].val);
		end
		prod      = PROD_W'(setpoint) * $signed(PROD_W'({1'b0, cnt}));
		sum_ext   = $signed(PROD_W'(sum));
		want      = (cnt != '0) && (sum_ext < prod);
		inc       = {1'b0, dwell_q} + (DWELL_W+1)'(1);
		dwell_sat = (inc < {1'b0, dwell_limit}) ? inc[DWELL_W-1:0] : dwell_limit;
		do_switch = (want != heater_q) && (dwell_sat >= dwell_limit);
		heater_next = do_switch ? want : heater_q;
		dwell_next  = do_switch ? '0 : dwell_sat;
	end

	always_comb begin
		priority if (unsafe_q) begin
			res.heater_on      = 1'b0;
			res.safety_latched = 1'b1;
		end else if (illegal) begin
			res.heater_on      = heater_q;
			res.safety_latched = 1'b1;
		end else begin
			res.heater_on      = heater_next;
			res.safety_latched = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heater_q <= 1'b0;
			dwell_q  <= DWELL_COUNT_RST;
			unsafe_q <= 1'b0;
		end else if (accept && !unsafe_q) begin
			if (illegal) begin
				unsafe_q <= 1'b1;
			end else begin
				heater_q <= heater_next;
				dwell_q  <= dwell_next;
			end
		end
	end

	a_latch_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		unsafe_q |=> unsafe_q)
		else $error("safety latch cleared without reset");

	a_state_frozen_latched: assert property (@(posedge clk) disable iff (!arst_n)
		unsafe_q |=> $stable(heater_q) && $stable(dwell_q))
		else $error("state moved while latched");

	a_switch_clears_dwell: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !unsafe_q && !illegal && (heater_next != heater_q) |=> dwell_q == '0)
		else $error("heater switched without clearing dwell counter");

	a_trip_holds_heater: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !unsafe_q && illegal |=> unsafe_q && heater_q == $past(heater_q))
		else $error("trip item changed heater state");
endmodule
`default_nettype wire

// ----- rtl/heater_bang_bang_with_safety_latch.sv -----
// top level: bang-bang heater controller with minimum dwell and safety latch
//
//  channel   dir  payload                                   handshake
//  sensor    in   temp_a, temp_b, temp_c, temp_d (13b sgn)  valid / ready
//  result    out  heater_on, safety_latched                 valid / ready
//  cfg       in   cfg_idx (3b), cfg_data (13b)              cfg_we, no wait
//
// one item per cycle while the skid entry is empty; the result is registered in out_q or skid_q
// lane checks, adder tree, multiply-compare and state update settle in the accepting cycle
// output register plus one skid entry: input stalls only when both are full
// async active-low reset: heater off, dwell counter saturated, latch clear
// no clearing pass; the block takes items right after reset
`timescale 1ns / 1ps
`default_nettype none
module heater_bang_bang_with_safety_latch #(
	parameter int NUM_SENSORS = hbb_pkg::NUM_SENSORS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	hbb_sensor_if.sink                       sensor,
	hbb_result_if.source                     result,
	input  logic                             cfg_we,
	input  logic [hbb_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [hbb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import hbb_pkg::*;

	localparam int LANES = (NUM_SENSORS < MAX_FIELDS) ? NUM_SENSORS : MAX_FIELDS;

	temp_t     setpoint_q;
	temp_t     min_legal_q;
	temp_t     max_legal_q;
	dwell_t    dwell_limit_q;
	temp_t     disconnect_q;

	temp_t     temps [MAX_FIELDS];
	hbb_lane_t lanes [LANES];
	hbb_res_t  res;
	logic      accept;
	logic      take;

	hbb_res_t  out_q;
	logic      out_v_q;
	hbb_res_t  skid_q;
	logic      skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q    <= SETPOINT_RST;
			min_legal_q   <= MIN_LEGAL_RST;
			max_legal_q   <= MAX_LEGAL_RST;
			dwell_limit_q <= DWELL_LIMIT_RST;
			disconnect_q  <= DISCONNECT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SETPOINT:    setpoint_q    <= cfg_data;
				REG_MIN_LEGAL:   min_legal_q   <= cfg_data;
				REG_MAX_LEGAL:   max_legal_q   <= cfg_data;
				REG_DWELL_LIMIT: dwell_limit_q <= cfg_data[DWELL_W-1:0];
				REG_DISCONNECT:  disconnect_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign temps[0] = sensor.temp_a;
	assign temps[1] = sensor.temp_b;
	assign temps[2] = sensor.temp_c;
	assign temps[3] = sensor.temp_d;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		hbb_lane u_lane (
			.temp       (temps[g]),
			.min_legal  (min_legal_q),
			.max_legal  (max_legal_q),
			.disconnect (disconnect_q),
			.lane       (lanes[g])
		);
	end

	assign sensor.ready = !skid_v_q;
	assign accept       = sensor.valid && sensor.ready;
	assign take         = out_v_q && result.ready;

	hbb_merge #(
		.LANES (LANES)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.lanes       (lanes),
		.setpoint    (setpoint_q),
		.dwell_limit (dwell_limit_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (take && skid_v_q) begin
				skid_v_q <= 1'b0;
			end else if (accept && out_v_q && !take) begin
				skid_v_q <= 1'b1;
			end
			if (accept) begin
				out_v_q <= 1'b1;
			end else if (take && !skid_v_q) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && skid_v_q) begin
			out_q <= skid_q;
		end
		if (accept) begin
			if (!out_v_q || (take && !skid_v_q)) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign result.valid          = out_v_q;
	assign result.heater_on      = out_q.heater_on;
	assign result.safety_latched = out_q.safety_latched;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without output entry");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_v_q)
		else $error("accepted item not buffered");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && skid_v_q |-> !accept)
		else $error("item accepted with buffer full");
endmodule
`default_nettype wire
